[sv/stage_sequence_timer_core_defines.svh]
// ---------------------------------------------------------------------------
// stage sequence timer assertion macros
// ---------------------------------------------------------------------------
`ifndef STAGE_SEQUENCE_TIMER_CORE_DEFINES_SVH
`define STAGE_SEQUENCE_TIMER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

[sv/sst_pkg.sv]
// ---------------------------------------------------------------------------
// sst_pkg
// Shared types and constants of the stage sequence timer.
// ---------------------------------------------------------------------------
package sst_pkg;

  // stage table size and fixed field widths
  localparam int unsigned STAGE_COUNT = 18;
  localparam int unsigned STAGE_W     = 5;
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned ELAPSED_W   = 17;
  localparam int unsigned PROG_W      = 17;
  localparam int unsigned QUO_W       = 16;
  localparam int unsigned DIV_CNT_W   = $clog2(QUO_W);
  localparam int unsigned CFG_ADDR_W  = 2;

  localparam logic [STAGE_W-1:0]   STAGE_LAST = STAGE_W'(STAGE_COUNT - 1);
  localparam logic [TIME_W-1:0]    PERIOD_MIN = 16'd250;
  localparam logic [TIME_W-1:0]    PERIOD_MAX = 16'd60000;
  localparam logic [TIME_W-1:0]    PERIOD_RST = 16'd3000;
  localparam logic [TIME_W-1:0]    DELTA_CAP  = 16'd60000;
  localparam logic [PROG_W-1:0]    Q16_ONE    = 17'h10000;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST   = DIV_CNT_W'(QUO_W - 1);

  // operation codes
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_NEXT    = 3'd1;
  localparam logic [2:0] OP_PREV    = 3'd2;
  localparam logic [2:0] OP_TOGGLE  = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WRAP   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BPAUSE = 2'd3;

  typedef struct packed {
    logic [2:0]        op;
    logic [TIME_W-1:0] delta_ms;
  } sst_in_t;

  typedef struct packed {
    logic               changed;
    logic [STAGE_W-1:0] stage_now;
    logic               is_paused;
    logic               is_done;
    logic [TIME_W-1:0]  remaining_ms;
    logic [PROG_W-1:0]  progress_q16;
  } sst_out_t;

  // controller to datapath
  typedef struct packed {
    logic apply;
    logic sub_step;
    logic div_start;
    logic div_step;
    logic load_out;
  } sst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sub_more;
    logic div_last;
  } sst_sts_t;

endpackage

[sv/sst_datapath.sv]
// ---------------------------------------------------------------------------
// sst_datapath
// Config registers, sequencer state, period subtractor, restoring Q16
// divider and the result register.
// ---------------------------------------------------------------------------
module sst_datapath import sst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [TIME_W-1:0]     cfg_wdata_i,
  input  sst_in_t               in_data_i,
  input  sst_cmd_t              cmd_i,
  output sst_sts_t              sts_o,
  output sst_out_t              out_data_o
);

  logic                 enable_q, enable_d;
  logic [TIME_W-1:0]    cfg_period_q, cfg_period_d;
  logic                 wrap_q, wrap_d;
  logic                 bpause_q, bpause_d;

  logic [STAGE_W-1:0]   stage_q, stage_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic                 paused_q, paused_d;
  logic                 done_q, done_d;
  logic                 changed_q, changed_d;
  logic                 tick_run_q, tick_run_d;

  logic [TIME_W-1:0]    rem_q, rem_d;
  logic [QUO_W-1:0]     quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  sst_out_t             out_q, out_d;

  logic [TIME_W-1:0]    period;
  logic [ELAPSED_W-1:0] period_x;
  logic [TIME_W-1:0]    delta_cap;
  logic [ELAPSED_W:0]   tick_sum;
  logic                 elapsed_ge;
  logic [ELAPSED_W-1:0] rem_shift;
  logic                 rem_ge;

  // period saturated to its legal range
  always_comb begin
    if (cfg_period_q < PERIOD_MIN) begin
      period = PERIOD_MIN;
    end else if (cfg_period_q > PERIOD_MAX) begin
      period = PERIOD_MAX;
    end else begin
      period = cfg_period_q;
    end
  end

  assign period_x   = {1'b0, period};
  assign delta_cap  = (in_data_i.delta_ms > DELTA_CAP) ? DELTA_CAP : in_data_i.delta_ms;
  assign tick_sum   = {1'b0, elapsed_q} + {2'b00, delta_cap};
  assign elapsed_ge = (elapsed_q >= period_x);
  assign rem_shift  = {rem_q, 1'b0};
  assign rem_ge     = (rem_shift >= period_x);

  assign sts_o.sub_more = tick_run_q && !done_q && elapsed_ge;
  assign sts_o.div_last = (cnt_q == DIV_LAST);

  // config writes
  always_comb begin
    enable_d     = enable_q;
    cfg_period_d = cfg_period_q;
    wrap_d       = wrap_q;
    bpause_d     = bpause_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ENABLE: enable_d     = cfg_wdata_i[0];
        CFG_PERIOD: cfg_period_d = cfg_wdata_i;
        CFG_WRAP:   wrap_d       = cfg_wdata_i[0];
        CFG_BPAUSE: bpause_d     = cfg_wdata_i[0];
      endcase
    end
  end

  // sequencer state: operation, then one period subtraction per step
  always_comb begin
    stage_d    = stage_q;
    elapsed_d  = elapsed_q;
    paused_d   = paused_q;
    done_d     = done_q;
    changed_d  = changed_q;
    tick_run_d = tick_run_q;
    if (cmd_i.apply) begin
      changed_d  = 1'b0;
      tick_run_d = 1'b0;
      unique case (in_data_i.op)
        OP_TICK: begin
          if (enable_q && !paused_q && !done_q && (in_data_i.delta_ms != '0)) begin
            elapsed_d  = tick_sum[ELAPSED_W-1:0];
            tick_run_d = 1'b1;
          end
        end
        OP_NEXT: begin
          if (enable_q && (stage_q < STAGE_LAST)) begin
            stage_d   = stage_q + 1'b1;
            elapsed_d = '0;
            done_d    = 1'b0;
            changed_d = 1'b1;
          end
        end
        OP_PREV: begin
          if (enable_q && (stage_q != '0)) begin
            stage_d   = stage_q - 1'b1;
            elapsed_d = '0;
            done_d    = 1'b0;
            changed_d = 1'b1;
          end
        end
        OP_TOGGLE: begin
          if (enable_q) begin
            paused_d = !paused_q;
          end
        end
        OP_RESTART: begin
          stage_d   = '0;
          elapsed_d = '0;
          done_d    = 1'b0;
          paused_d  = enable_q && bpause_q;
        end
        default: ;
      endcase
    end else if (cmd_i.sub_step) begin
      if (stage_q < STAGE_LAST) begin
        stage_d   = stage_q + 1'b1;
        elapsed_d = elapsed_q - period_x;
        changed_d = 1'b1;
      end else if (wrap_q) begin
        stage_d   = '0;
        elapsed_d = elapsed_q - period_x;
        changed_d = 1'b1;
      end else begin
        // last stage without wrap: complete and drop leftover time
        elapsed_d = period_x;
        done_d    = 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (cmd_i.div_start) begin
      rem_d = elapsed_q[TIME_W-1:0];
      quo_d = '0;
      cnt_d = '0;
    end else if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_d = TIME_W'(rem_shift - period_x);
      end else begin
        rem_d = rem_shift[TIME_W-1:0];
      end
      quo_d = {quo_q[QUO_W-2:0], rem_ge};
      cnt_d = cnt_q + 1'b1;
    end
  end

  // result register
  always_comb begin
    out_d = out_q;
    if (cmd_i.load_out) begin
      out_d.changed   = changed_q;
      out_d.stage_now = stage_q;
      out_d.is_paused = paused_q;
      out_d.is_done   = done_q;
      if (done_q || elapsed_ge) begin
        out_d.remaining_ms = '0;
        out_d.progress_q16 = Q16_ONE;
      end else begin
        out_d.remaining_ms = TIME_W'(period_x - elapsed_q);
        out_d.progress_q16 = {1'b0, quo_q};
      end
    end
  end

  // control and config state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      cfg_period_q <= PERIOD_RST;
      wrap_q       <= 1'b0;
      bpause_q     <= 1'b0;
      stage_q      <= '0;
      elapsed_q    <= '0;
      paused_q     <= 1'b0;
      done_q       <= 1'b0;
      changed_q    <= 1'b0;
      tick_run_q   <= 1'b0;
      cnt_q        <= '0;
    end else begin
      enable_q     <= enable_d;
      cfg_period_q <= cfg_period_d;
      wrap_q       <= wrap_d;
      bpause_q     <= bpause_d;
      stage_q      <= stage_d;
      elapsed_q    <= elapsed_d;
      paused_q     <= paused_d;
      done_q       <= done_d;
      changed_q    <= changed_d;
      tick_run_q   <= tick_run_d;
      cnt_q        <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

[sv/sst_ctrl.sv]
// ---------------------------------------------------------------------------
// sst_ctrl
// Sequencing state machine: accept, period subtraction loop, divide,
// result transfer.
// ---------------------------------------------------------------------------
module sst_ctrl import sst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sst_cmd_t cmd_o,
  input  sst_sts_t sts_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUB  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // result register can take a new value this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_SUB;
        end
      end
      ST_SUB: begin
        if (sts_i.sub_more) begin
          cmd_o.sub_step = 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[sv/stage_sequence_timer_core.sv]
// ---------------------------------------------------------------------------
// stage_sequence_timer_core
// Timed stage sequencer with millisecond ticks and Q16 progress.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one op and
//   a delta in ms; output channel (out_valid_o / out_stall_i / out_data_o)
//   returns exactly one result per input transfer.
//   Config is a plain write port (cfg_we_i, cfg_addr_i, cfg_wdata_i); the user
//   writes it only while the block is idle, which the block does not enforce.
// Timing:
//   An item is applied, then runs the period subtraction loop once for each
//   whole period the tick consumes (never for other ops, at most 479 times),
//   then the Q16 divider, and its result is loaded into the output register.
//   The loop runs one subtraction per cycle and the Q16 divider resolves one
//   quotient bit per cycle (16 bits). One item is in work at a time.
// Reset:
//   Clears stage, elapsed time and flags, loads the config defaults
//   (disabled, 3000 ms period) and empties the output register.
// Stall:
//   A result held by out_stall_i stays put; the next item is still taken
//   and worked on, then waits in the output stage until the register frees.
// ---------------------------------------------------------------------------
module stage_sequence_timer_core import sst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [TIME_W-1:0]     cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sst_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sst_out_t              out_data_o
);

  sst_cmd_t cmd;
  sst_sts_t sts;

  // controller
  sst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath
  sst_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/sst_checker.sv]
// ---------------------------------------------------------------------------
// sst_checker
// Port-level checks of the stage sequence timer, bound to the top level.
// ---------------------------------------------------------------------------
`include "stage_sequence_timer_core_defines.svh"

module sst_checker import sst_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input sst_out_t              out_data_o
);

  // stalled result stays offered and unchanged
  `SST_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `SST_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_data_o), "result changed while stalled")

  // one item in work: input stalls right after a transfer
  `SST_ASSERT_NEXT(a_busy_after_in, in_valid_i && !in_stall_o, in_stall_o, "input taken while busy")

  // completed sequence reports full progress and no time left
  `SST_ASSERT_NOW(a_done_full, out_valid_o && out_data_o.is_done, (out_data_o.remaining_ms == '0) && (out_data_o.progress_q16 == Q16_ONE), "done result not saturated")

  // progress never exceeds one in Q16
  `SST_ASSERT_NOW(a_prog_max, out_valid_o, !out_data_o.progress_q16[PROG_W-1] || (out_data_o.progress_q16[PROG_W-2:0] == '0), "progress above one")

endmodule

bind stage_sequence_timer_core sst_checker u_sst_checker (.*);

[test/stage_sequence_timer_core_tb.sv]
// ---------------------------------------------------------------------------
// stage_sequence_timer_core_tb
// Self-checking bench for the timed stage sequencer. A directed table covers
// the disabled, paused, completion, bound and restart corners, then random
// phases with fresh register settings drive mostly ticks and steps. Every
// result transfer is compared field by field with the table's typed status or
// else a cycle-free model of the sequencer run on each accepted input transfer.
// ---------------------------------------------------------------------------
module stage_sequence_timer_core_tb;
  import sst_pkg::*;

  // op codes the block leaves undefined
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 75;
  localparam int unsigned QUIET_LIMIT     = 5000;
  localparam int unsigned SETTLE_CYCLES   = 600;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e               kind;
    logic [2:0]              op;
    logic [CFG_ADDR_W-1:0]   addr;
    logic [TIME_W-1:0]       value;
    bit                      typed;
    sst_out_t                status;
  } plan_row_t;

  // clock, reset and block ports
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [TIME_W-1:0]     cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  sst_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sst_out_t              out_data;

  // expectation typed into the table for the item on the input channel
  bit                    row_typed  = 1'b0;
  sst_out_t              row_status = '0;

  // sequencer state and register copy
  logic [STAGE_W-1:0]    stage_q      = '0;
  logic [ELAPSED_W-1:0]  elapsed_q    = '0;
  bit                    paused_q     = 1'b0;
  bit                    done_q       = 1'b0;
  bit                    en_q         = 1'b0;
  bit                    wrap_q       = 1'b0;
  bit                    bpause_q     = 1'b0;
  logic [TIME_W-1:0]     period_reg_q = PERIOD_RST;

  sst_out_t              pending_status_q[$];
  sst_out_t              predicted_status;
  sst_out_t              wanted_status;
  plan_row_t             plan[$];
  int unsigned           mismatch_cnt = 0;
  int unsigned           quiet_cycles = 0;
  int unsigned           stall_left   = 0;
  bit                    idling_on    = 1'b1;

  always #10 clk = ~clk;

  stage_sequence_timer_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // stage period after saturation
  function automatic int unsigned period_in_use();
    if (period_reg_q < PERIOD_MIN) return PERIOD_MIN;
    if (period_reg_q > PERIOD_MAX) return PERIOD_MAX;
    return period_reg_q;
  endfunction

  // apply one op to the sequencer state and return the status it reports
  function automatic sst_out_t step_sequencer(input sst_in_t item);
    sst_out_t    st;
    int unsigned period;
    int unsigned el;
    period = period_in_use();
    el     = elapsed_q;
    st     = '0;
    case (item.op)
      OP_TICK: begin
        if (en_q && !paused_q && !done_q && item.delta_ms != '0) begin
          el += (item.delta_ms > DELTA_CAP) ? DELTA_CAP : item.delta_ms;
          // one stage per whole period; completion pins elapsed at the period
          while (el >= period && !done_q) begin
            el -= period;
            if (stage_q < STAGE_LAST) begin
              stage_q++;
              st.changed = 1'b1;
            end else if (wrap_q) begin
              stage_q    = '0;
              st.changed = 1'b1;
            end else begin
              el     = period;
              done_q = 1'b1;
            end
          end
        end
      end
      OP_NEXT: begin
        if (en_q && stage_q < STAGE_LAST) begin
          stage_q++;
          el         = 0;
          done_q     = 1'b0;
          st.changed = 1'b1;
        end
      end
      OP_PREV: begin
        if (en_q && stage_q != '0) begin
          stage_q--;
          el         = 0;
          done_q     = 1'b0;
          st.changed = 1'b1;
        end
      end
      OP_TOGGLE: begin
        if (en_q) paused_q = !paused_q;
      end
      OP_RESTART: begin
        stage_q  = '0;
        el       = 0;
        done_q   = 1'b0;
        paused_q = en_q & bpause_q;
      end
      default: ;
    endcase
    elapsed_q    = ELAPSED_W'(el);
    st.stage_now = stage_q;
    st.is_paused = paused_q;
    st.is_done   = done_q;
    // done or overrun reads as a full stage
    if (done_q || el >= period) begin
      st.remaining_ms = '0;
      st.progress_q16 = Q16_ONE;
    end else begin
      st.remaining_ms = TIME_W'(period - el);
      st.progress_q16 = PROG_W'((64'(el) << 16) / period);
    end
    return st;
  endfunction

  function automatic sst_out_t status_of(input bit ch, input int unsigned stg, input bit pau,
                                         input bit dn, input int unsigned rem,
                                         input int unsigned prog);
    sst_out_t st;
    st.changed      = ch;
    st.stage_now    = STAGE_W'(stg);
    st.is_paused    = pau;
    st.is_done      = dn;
    st.remaining_ms = TIME_W'(rem);
    st.progress_q16 = PROG_W'(prog);
    return st;
  endfunction

  // table rows
  function automatic void plan_item(input logic [2:0] op, input int unsigned delta);
    plan_row_t r;
    r        = '{kind: ROW_ITEM, op: op, addr: '0, value: TIME_W'(delta), typed: 1'b0,
                 status: '0};
    plan.push_back(r);
  endfunction

  function automatic void plan_checked(input logic [2:0] op, input int unsigned delta,
                                       input sst_out_t st);
    plan_row_t r;
    r        = '{kind: ROW_ITEM, op: op, addr: '0, value: TIME_W'(delta), typed: 1'b1,
                 status: st};
    plan.push_back(r);
  endfunction

  function automatic void plan_write(input logic [CFG_ADDR_W-1:0] addr,
                                     input int unsigned value);
    plan_row_t r;
    r        = '{kind: ROW_CFG, op: OP_TICK, addr: addr, value: TIME_W'(value), typed: 1'b0,
                 status: '0};
    plan.push_back(r);
  endfunction

  // present one item and hold it until the transfer; entered and left at a falling edge
  task automatic send_op(input sst_in_t item, input bit typed, input sst_out_t st);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data    <= item;
    row_typed  <= typed;
    row_status <= st;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // register write once every outstanding result has come back
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [TIME_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_status_q.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      CFG_ENABLE: en_q         = data[0];
      CFG_PERIOD: period_reg_q = data;
      CFG_WRAP:   wrap_q       = data[0];
      CFG_BPAUSE: bpause_q     = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // random item, steered toward ticks and out of paused or done states
  task automatic send_random_item();
    sst_in_t     item;
    int unsigned period;
    int unsigned pick;
    period        = period_in_use();
    pick          = $urandom_range(0, 99);
    item.op       = OP_TICK;
    item.delta_ms = TIME_W'($urandom);
    if (paused_q && pick < 40) begin
      item.op = OP_TOGGLE;
    end else if (done_q && pick < 30) begin
      item.op = OP_RESTART;
    end else if (pick < 60) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: item.delta_ms = TIME_W'($urandom_range(1, (2 * period > 65535) ?
                                                                     65535 : 2 * period));
        6, 7:             item.delta_ms = TIME_W'($urandom);
        8:                item.delta_ms = (elapsed_q < period) ?
                                          TIME_W'(period - elapsed_q) : TIME_W'(1);
        default:          item.delta_ms = TIME_W'($urandom_range(0, 3));
      endcase
    end else if (pick < 72) begin
      item.op = OP_NEXT;
    end else if (pick < 82) begin
      item.op = OP_PREV;
    end else if (pick < 88) begin
      item.op = OP_TOGGLE;
    end else if (pick < 94) begin
      item.op = OP_RESTART;
    end else begin
      item.op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
    end
    send_op(item, 1'b0, '0);
  endtask

  // one flag register: bit 0 counts, upper bits are random filler
  function automatic logic [TIME_W-1:0] flag_word(input bit flag);
    return {15'($urandom), flag};
  endfunction

  // expectation per accepted input transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predicted_status = step_sequencer(in_data);
      pending_status_q.push_back(row_typed ? row_status : predicted_status);
    end
  end

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_status_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
        mismatch_cnt++;
      end else begin
        wanted_status = pending_status_q.pop_front();
        check_field("changed", wanted_status.changed, out_data.changed);
        check_field("stage_now", wanted_status.stage_now, out_data.stage_now);
        check_field("is_paused", wanted_status.is_paused, out_data.is_paused);
        check_field("is_done", wanted_status.is_done, out_data.is_done);
        check_field("remaining_ms", wanted_status.remaining_ms, out_data.remaining_ms);
        check_field("progress_q16", wanted_status.progress_q16, out_data.progress_q16);
      end
    end
  end

  // result-side backpressure in bursts of random length, only while idling is on
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    bit          en;
    int unsigned per;

    // disabled after reset: everything but restart is ignored
    plan_checked(OP_TICK, 1000, status_of(0, 0, 0, 0, 3000, 0));
    plan_checked(OP_NEXT, 0, status_of(0, 0, 0, 0, 3000, 0));
    plan_checked(OP_TOGGLE, 0, status_of(0, 0, 0, 0, 3000, 0));
    plan_checked(OP_RSVD7, 65535, status_of(0, 0, 0, 0, 3000, 0));
    // period below range saturates to the minimum; restart comes up paused
    plan_write(CFG_ENABLE, 1);
    plan_write(CFG_PERIOD, 0);
    plan_write(CFG_BPAUSE, 1);
    plan_checked(OP_RESTART, 0, status_of(0, 0, 1, 0, 250, 0));
    plan_checked(OP_TICK, 100, status_of(0, 0, 1, 0, 250, 0));
    plan_checked(OP_TOGGLE, 0, status_of(0, 0, 0, 0, 250, 0));
    plan_checked(OP_TICK, 0, status_of(0, 0, 0, 0, 250, 0));
    plan_checked(OP_PREV, 0, status_of(0, 0, 0, 0, 250, 0));
    // capped delta runs through every stage and completes
    plan_checked(OP_TICK, 65535, status_of(1, 17, 0, 1, 0, 65536));
    plan_checked(OP_TICK, 5, status_of(0, 17, 0, 1, 0, 65536));
    plan_checked(OP_NEXT, 0, status_of(0, 17, 0, 1, 0, 65536));
    plan_checked(OP_PREV, 0, status_of(1, 16, 0, 0, 250, 0));
    plan_item(OP_TICK, 125);
    plan_item(OP_NEXT, 0);
    // period above range saturates to the maximum; wrap from the last stage
    plan_write(CFG_PERIOD, 65535);
    plan_write(CFG_WRAP, 1);
    plan_item(OP_TICK, 65535);
    plan_item(OP_TICK, 59999);
    // shrink the period under the elapsed count
    plan_write(CFG_PERIOD, 250);
    plan_item(OP_TOGGLE, 0);
    plan_item(OP_TOGGLE, 0);
    plan_item(OP_TICK, 1);
    // restart while disabled does not pause
    plan_write(CFG_ENABLE, 0);
    plan_checked(OP_RESTART, 0, status_of(0, 0, 0, 0, 250, 0));
    plan_item(OP_RSVD5, 0);
    plan_item(OP_RSVD6, 0);
    plan_write(CFG_ENABLE, 1);
    plan_write(CFG_PERIOD, PERIOD_MAX);
    plan_write(CFG_WRAP, 0);
    plan_write(CFG_BPAUSE, 0);
    plan_item(OP_NEXT, 0);
    plan_item(OP_TICK, 60000);

    // reset
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].addr, plan[i].value);
      end else begin
        send_op('{op: plan[i].op, delta_ms: plan[i].value}, plan[i].typed, plan[i].status);
      end
    end

    // random phases, each with its own register settings; the last one runs flat out
    for (int ph = 0; ph < PHASES; ph++) begin
      idling_on = (ph != PHASES - 1);
      en        = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 7))
        0:       per = $urandom_range(0, PERIOD_MIN - 1);
        1:       per = $urandom_range(PERIOD_MAX + 1, 65535);
        2:       per = PERIOD_MIN;
        3:       per = PERIOD_MAX;
        default: per = $urandom_range(PERIOD_MIN, 2500);
      endcase
      write_reg(CFG_ENABLE, flag_word(en));
      write_reg(CFG_PERIOD, TIME_W'(per));
      write_reg(CFG_WRAP, flag_word($urandom_range(0, 1)));
      write_reg(CFG_BPAUSE, flag_word($urandom_range(0, 1)));
      repeat (ITEMS_PER_PHASE) send_random_item();
    end

    // drain and watch for stray results
    in_valid <= 1'b0;
    while (pending_status_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[stage_sequence_timer_core.f]
+incdir+sv
sv/sst_pkg.sv
sv/sst_datapath.sv
sv/sst_ctrl.sv
sv/stage_sequence_timer_core.sv
sv/sst_checker.sv
test/stage_sequence_timer_core_tb.sv
